[hw/rtl/sobel_edge_magnitude_rgb_assert.svh]
// assertion macros shared by the sobel edge magnitude rtl
// no dependencies; bodies are empty when SYNTH is defined
`ifndef SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH
`define SOBEL_EDGE_MAGNITUDE_RGB_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define SEM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define SEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SEM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define SEM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[hw/rtl/sem_pkg.sv]
// shared constants and types for the sobel edge magnitude block
// no dependencies
package sem_pkg;

	// pixel and channel geometry
	localparam int PIX_W  = 8;
	localparam int CH_N   = 3;
	localparam int RGB_W  = PIX_W * CH_N;
	localparam int TAP_N  = 9;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

	// register widths, reset values and limits
	localparam int WIDTH_W       = 11;
	localparam int HEIGHT_W      = 13;
	localparam int ROW_W         = 13;
	localparam int OROW_W        = 12;
	localparam int MIN_DIM       = 2;
	localparam int HEIGHT_LIMIT  = 4096;
	localparam int WIDTH_RESET   = 640;
	localparam int HEIGHT_RESET  = 480;
	localparam int DEF_MAX_WIDTH = 1024;

	// magnitude saturation
	localparam int SAT_LEVEL = 255;
	localparam int SAT_SUM   = SAT_LEVEL * SAT_LEVEL + SAT_LEVEL;

	// lane pipeline depth and result queue
	localparam int LANE_LAT   = 8;
	localparam int FIFO_DEPTH = 16;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = FIFO_AW + 1;

	// one channel of the 3x3 window, row-major, top-left first
	typedef logic [TAP_N-1:0][PIX_W-1:0] lane_taps_t;

endpackage

[hw/rtl/sobel_edge_magnitude_rgb.sv]
// 3x3 sobel edge magnitude on rgb pixels: line stores, window, three lanes, result queue
// depends on sem_pkg, sem_ram, sem_lane and sobel_edge_magnitude_rgb_assert.svh
// throughput: one pixel per cycle when ready, set by each line store's lone read and write port
// latency: a pixel's result needs image_width+1 later items, then stage 1, stage 2 and the lanes
// 16-entry result queue with credit count; s_axis_tready is not combinational on m_axis_tready
// reset: position counters cleared, width 640, height 480, window zeroed; line stores not cleared
module sobel_edge_magnitude_rgb #(
	parameter int MAX_WIDTH = sem_pkg::DEF_MAX_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// pixel input
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [sem_pkg::RGB_W-1:0]      s_axis_tdata,  // red_in, green_in, blue_in
	input  logic                           s_axis_tuser,  // drain
	// edge output
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [sem_pkg::RGB_W-1:0]      m_axis_tdata,  // red_edge, green_edge, blue_edge
	output logic                           m_axis_tlast,  // end_of_frame
	// register writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);
	import sem_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WU_W  = (WIDTH_W > $clog2(MAX_WIDTH + 1)) ? WIDTH_W : $clog2(MAX_WIDTH + 1);
	localparam int QW    = RGB_W + 1;

	// configuration
	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic                cfg_acc, cfg_hit;

	// clamped geometry
	logic [WU_W-1:0]     w_ext, w_used;
	logic [COL_W-1:0]    w_m1;
	logic [HEIGHT_W-1:0] h_used;
	logic [OROW_W-1:0]   h_m1;

	// position counters
	logic [COL_W-1:0]  in_col_q, out_col_q;
	logic [ROW_W-1:0]  in_row_q;
	logic [OROW_W-1:0] out_row_q;

	// stage 0 decisions
	logic             s_acc, pix_ok, case_a_c, emit_c, eof_c;
	logic             row_top_c, row_bot_c, col_l_c, col_r_c;
	logic [RGB_W-1:0] pix_c;

	// stage 1
	logic             vld_s1, emit_s1, eof_s1, case_a_s1, byp_s1;
	logic             row_top_s1, row_bot_s1, col_l_s1, col_r_s1;
	logic [RGB_W-1:0] pix_s1, byp_up_s1, byp_mid_s1;
	logic [COL_W-1:0] addr_s1;
	logic [RGB_W-1:0] up_rd, mid_rd, top_c, mid_c;
	logic [RGB_W-1:0] win_q [TAP_N];
	logic [RGB_W-1:0] taps_c [TAP_N];

	// stage 2 and lane alignment
	logic             vld_s2, eof_s2;
	logic [RGB_W-1:0] taps_s2 [TAP_N];
	logic             vld_sh_q [LANE_LAT];
	logic             eof_sh_q [LANE_LAT];
	lane_taps_t       lane_taps [CH_N];
	logic [PIX_W-1:0] lane_edge [CH_N];

	// result queue and credits
	logic [QW-1:0]      fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   fifo_cnt_q, inflight_q;
	logic               fifo_wr, m_acc, drop;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid & cfg_ready;
	assign cfg_hit   = cfg_acc &&
		((cfg_index == REG_IMAGE_WIDTH) || (cfg_index == REG_IMAGE_HEIGHT));

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_W'(WIDTH_RESET);
			height_q <= HEIGHT_W'(HEIGHT_RESET);
		end else if (cfg_acc) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp width and height
	always_comb begin
		w_ext = WU_W'(width_q);
		if (w_ext < WU_W'(MIN_DIM)) begin
			w_used = WU_W'(MIN_DIM);
		end else if (w_ext > WU_W'(MAX_WIDTH)) begin
			w_used = WU_W'(MAX_WIDTH);
		end else begin
			w_used = w_ext;
		end
		w_m1 = COL_W'(w_used - WU_W'(1));
		if (height_q < HEIGHT_W'(MIN_DIM)) begin
			h_used = HEIGHT_W'(MIN_DIM);
		end else if (height_q > HEIGHT_W'(HEIGHT_LIMIT)) begin
			h_used = HEIGHT_W'(HEIGHT_LIMIT);
		end else begin
			h_used = height_q;
		end
		h_m1 = OROW_W'(h_used - HEIGHT_W'(1));
	end

	// stage 0: what the incoming transaction does
	assign s_axis_tready = (inflight_q < CNT_W'(FIFO_DEPTH));
	assign s_acc     = s_axis_tvalid & s_axis_tready;
	assign pix_ok    = !s_axis_tuser && (in_row_q < h_used);
	assign pix_c     = pix_ok ? s_axis_tdata : '0;
	assign case_a_c  = (in_col_q == '0) && (in_row_q >= ROW_W'(2));
	assign emit_c    = case_a_c || ((in_col_q != '0) && (in_row_q >= ROW_W'(1)));
	assign row_top_c = (out_row_q == '0);
	assign row_bot_c = (out_row_q >= h_m1);
	assign col_l_c   = (out_col_q == '0);
	assign col_r_c   = (out_col_q >= w_m1);
	assign eof_c     = emit_c && row_bot_c && col_r_c;

	// position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_hit || (s_acc && eof_c)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (s_acc) begin
			if (in_col_q >= w_m1) begin
				in_col_q <= '0;
				if (in_row_q != '1) begin
					in_row_q <= in_row_q + ROW_W'(1);
				end
			end else begin
				in_col_q <= in_col_q + COL_W'(1);
			end
			if (emit_c) begin
				if (col_r_c) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + OROW_W'(1);
				end else begin
					out_col_q <= out_col_q + COL_W'(1);
				end
			end
		end
	end

	// stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= s_acc;
		end
	end

	// stage 1 payload, with forwarding of the write that lands on the read edge
	always_ff @(posedge clk) begin
		if (s_acc) begin
			pix_s1     <= pix_c;
			addr_s1    <= in_col_q;
			emit_s1    <= emit_c;
			eof_s1     <= eof_c;
			case_a_s1  <= case_a_c;
			row_top_s1 <= row_top_c;
			row_bot_s1 <= row_bot_c;
			col_l_s1   <= col_l_c;
			col_r_s1   <= col_r_c;
			byp_s1     <= vld_s1 && (addr_s1 == in_col_q);
			byp_up_s1  <= mid_c;
			byp_mid_s1 <= pix_s1;
		end
	end

	// line stores: upper row and middle row
	sem_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_upper_ram (
		.clk   (clk),
		.we    (vld_s1),
		.waddr (addr_s1),
		.wdata (mid_c),
		.re    (s_acc),
		.raddr (in_col_q),
		.rdata (up_rd)
	);

	sem_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_middle_ram (
		.clk   (clk),
		.we    (vld_s1),
		.waddr (addr_s1),
		.wdata (pix_s1),
		.re    (s_acc),
		.raddr (in_col_q),
		.rdata (mid_rd)
	);

	assign top_c = byp_s1 ? byp_up_s1 : up_rd;
	assign mid_c = byp_s1 ? byp_mid_s1 : mid_rd;

	// window taps with border masking
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			taps_c[r*3]     = win_q[r*3+1];
			taps_c[r*3 + 1] = win_q[r*3+2];
		end
		if (case_a_s1) begin
			taps_c[2] = '0;
			taps_c[5] = '0;
			taps_c[8] = '0;
		end else begin
			taps_c[2] = top_c;
			taps_c[5] = mid_c;
			taps_c[8] = pix_s1;
		end
		for (int k = 0; k < 3; k++) begin
			if (row_top_s1) taps_c[k] = '0;
			if (row_bot_s1) taps_c[6 + k] = '0;
			if (col_l_s1) taps_c[k*3] = '0;
			if (col_r_s1) taps_c[k*3 + 2] = '0;
		end
	end

	// window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TAP_N; k++) begin
				win_q[k] <= '0;
			end
		end else if (vld_s1) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r*3]     <= win_q[r*3+1];
				win_q[r*3 + 1] <= win_q[r*3+2];
			end
			win_q[2] <= top_c;
			win_q[5] <= mid_c;
			win_q[8] <= pix_s1;
		end
	end

	// stage 2 and the valid line that runs beside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
			for (int i = 0; i < LANE_LAT; i++) begin
				vld_sh_q[i] <= 1'b0;
			end
		end else begin
			vld_s2      <= vld_s1 && emit_s1;
			vld_sh_q[0] <= vld_s2;
			for (int i = 1; i < LANE_LAT; i++) begin
				vld_sh_q[i] <= vld_sh_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		eof_s2      <= eof_s1;
		eof_sh_q[0] <= eof_s2;
		for (int i = 1; i < LANE_LAT; i++) begin
			eof_sh_q[i] <= eof_sh_q[i-1];
		end
		for (int k = 0; k < TAP_N; k++) begin
			taps_s2[k] <= taps_c[k];
		end
	end

	// one lane per color channel
	for (genvar c = 0; c < CH_N; c++) begin : g_lane
		always_comb begin
			for (int k = 0; k < TAP_N; k++) begin
				lane_taps[c][k] = taps_s2[k][c*PIX_W +: PIX_W];
			end
		end

		sem_lane u_lane (
			.clk      (clk),
			.taps     (lane_taps[c]),
			.edge_mag (lane_edge[c])
		);
	end

	// merge lane results into the queue
	assign fifo_wr = vld_sh_q[LANE_LAT-1];
	assign m_acc   = m_axis_tvalid & m_axis_tready;
	assign drop    = vld_s1 && !emit_s1;

	always_ff @(posedge clk) begin
		if (fifo_wr) begin
			fifo_q[wr_ptr_q] <= {eof_sh_q[LANE_LAT-1], lane_edge[2], lane_edge[1], lane_edge[0]};
		end
	end

	// queue pointers and credit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			inflight_q <= '0;
		end else begin
			if (fifo_wr) wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (m_acc) rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			fifo_cnt_q <= fifo_cnt_q + CNT_W'(fifo_wr) - CNT_W'(m_acc);
			inflight_q <= inflight_q + CNT_W'(s_acc) - CNT_W'(drop) - CNT_W'(m_acc);
		end
	end

	assign m_axis_tvalid = (fifo_cnt_q != '0);
	assign m_axis_tdata  = fifo_q[rd_ptr_q][RGB_W-1:0];
	assign m_axis_tlast  = fifo_q[rd_ptr_q][RGB_W];

	// checks
`include "sobel_edge_magnitude_rgb_assert.svh"

	`SEM_ASSERT_IMPL(a_credit_bound, clk, arst_n, 1'b1, inflight_q <= CNT_W'(FIFO_DEPTH), "credit count above queue depth")
	`SEM_ASSERT_IMPL(a_queue_covered, clk, arst_n, 1'b1, fifo_cnt_q <= inflight_q, "queue holds more results than credits taken")
	`SEM_ASSERT_IMPL(a_no_overflow, clk, arst_n, fifo_wr, (fifo_cnt_q < CNT_W'(FIFO_DEPTH)) || m_acc, "result queue overflow")
	`SEM_ASSERT_NEXT(a_frame_restart, clk, arst_n, s_acc && eof_c, (in_col_q == '0) && (in_row_q == '0) && (out_col_q == '0) && (out_row_q == '0), "counters not cleared after frame end")

endmodule

[hw/rtl/sem_ram.sv]
// generic simple dual-port ram with registered read-first output
// no dependencies
module sem_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rd_data_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_data_q;

endmodule

[hw/rtl/sem_lane.sv]
// one color channel: sobel gradients, squared sum and rounded square root
// depends on sem_pkg; taps pass through the gradient, square, sum, root and rounding registers to edge_mag
module sem_lane (
	input  logic                      clk,
	input  sem_pkg::lane_taps_t       taps,
	output logic [sem_pkg::PIX_W-1:0] edge_mag
);
	import sem_pkg::*;

	localparam int SUM_W  = PIX_W + 2;
	localparam int GRAD_W = SUM_W + 1;
	localparam int PROD_W = 2 * GRAD_W;
	localparam int SQ_W   = 20;
	localparam int ACC_W  = SQ_W + 1;
	localparam int VAL_W  = 2 * PIX_W;
	localparam int REM_W  = PIX_W + 2;
	localparam int STEP_W = REM_W + PIX_W;

	// one bit of the restoring square root: {remainder, root}
	function automatic logic [STEP_W-1:0] root_step(
		input logic [REM_W-1:0] rem,
		input logic [PIX_W-1:0] root,
		input logic [1:0]       pair
	);
		logic [REM_W+1:0] cur;
		logic [REM_W+1:0] trial;
		cur   = {rem, pair};
		trial = {2'b00, root, 2'b01};
		if (cur >= trial) begin
			root_step = {REM_W'(cur - trial), root[PIX_W-2:0], 1'b1};
		end else begin
			root_step = {cur[REM_W-1:0], root[PIX_W-2:0], 1'b0};
		end
	endfunction

	logic [SUM_W-1:0]         pos_x, neg_x, pos_y, neg_y;
	logic signed [GRAD_W-1:0] gx_s1, gy_s1;
	logic signed [PROD_W-1:0] prod_x, prod_y;
	logic [SQ_W-1:0]          gx2_s2, gy2_s2;
	logic [ACC_W-1:0]         acc;
	logic [VAL_W-1:0]         val_s3, val_s4, val_s5, val_s6;
	logic                     sat_s3, sat_s4, sat_s5, sat_s6, sat_s7;
	logic [STEP_W-1:0]        st4a, st4b, st5a, st5b, st6a, st6b, st7a, st7b;
	logic [PIX_W-1:0]         root_s4, root_s5, root_s6, root_s7;
	logic [REM_W-1:0]         rem_s4, rem_s5, rem_s6, rem_s7;
	logic [PIX_W-1:0]         edge_s8;

	// weighted column and row sums
	always_comb begin
		pos_x = SUM_W'(taps[2]) + {1'b0, taps[5], 1'b0} + SUM_W'(taps[8]);
		neg_x = SUM_W'(taps[0]) + {1'b0, taps[3], 1'b0} + SUM_W'(taps[6]);
		pos_y = SUM_W'(taps[6]) + {1'b0, taps[7], 1'b0} + SUM_W'(taps[8]);
		neg_y = SUM_W'(taps[0]) + {1'b0, taps[1], 1'b0} + SUM_W'(taps[2]);
	end

	// squares and their sum
	assign prod_x = gx_s1 * gx_s1;
	assign prod_y = gy_s1 * gy_s1;
	assign acc    = {1'b0, gx2_s2} + {1'b0, gy2_s2};

	// two root bits per stage
	always_comb begin
		st4a = root_step('0, '0, val_s3[15:14]);
		st4b = root_step(st4a[STEP_W-1:PIX_W], st4a[PIX_W-1:0], val_s3[13:12]);
		st5a = root_step(rem_s4, root_s4, val_s4[11:10]);
		st5b = root_step(st5a[STEP_W-1:PIX_W], st5a[PIX_W-1:0], val_s4[9:8]);
		st6a = root_step(rem_s5, root_s5, val_s5[7:6]);
		st6b = root_step(st6a[STEP_W-1:PIX_W], st6a[PIX_W-1:0], val_s5[5:4]);
		st7a = root_step(rem_s6, root_s6, val_s6[3:2]);
		st7b = root_step(st7a[STEP_W-1:PIX_W], st7a[PIX_W-1:0], val_s6[1:0]);
	end

	// lane pipeline
	always_ff @(posedge clk) begin
		gx_s1   <= $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
		gy_s1   <= $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
		gx2_s2  <= prod_x[SQ_W-1:0];
		gy2_s2  <= prod_y[SQ_W-1:0];
		val_s3  <= acc[VAL_W-1:0];
		sat_s3  <= (acc > ACC_W'(SAT_SUM));
		{rem_s4, root_s4} <= st4b;
		val_s4  <= val_s3;
		sat_s4  <= sat_s3;
		{rem_s5, root_s5} <= st5b;
		val_s5  <= val_s4;
		sat_s5  <= sat_s4;
		{rem_s6, root_s6} <= st6b;
		val_s6  <= val_s5;
		sat_s6  <= sat_s5;
		{rem_s7, root_s7} <= st7b;
		sat_s7  <= sat_s6;
		// round to nearest: up when remainder exceeds the root
		if (sat_s7) begin
			edge_s8 <= PIX_W'(SAT_LEVEL);
		end else if (rem_s7 > REM_W'(root_s7)) begin
			edge_s8 <= root_s7 + PIX_W'(1);
		end else begin
			edge_s8 <= root_s7;
		end
	end

	assign edge_mag = edge_s8;

endmodule
